FILE: hdl/ucfd_pkg.sv
// shared types and constants for the uart can frame deframer
// no dependencies; imported by uart_can_frame_deframer_unit
`timescale 1ns / 1ps

package ucfd_pkg;

  localparam int unsigned MAX_PAYLOAD = 8;
  localparam int unsigned PIDX_W      = $clog2(MAX_PAYLOAD);

  localparam logic [7:0] START_BYTE   = 8'h40;
  localparam logic [7:0] TRAILER_BYTE = 8'h1A;
  localparam logic [7:0] TYPE_STD     = 8'h00;
  localparam logic [7:0] TYPE_EXT     = 8'h08;

  localparam logic [2:0] ID_LEN_STD = 3'd2;
  localparam logic [2:0] ID_LEN_EXT = 3'd4;
  localparam logic [2:0] HDR_STD    = 3'd3;
  localparam logic [2:0] HDR_EXT    = 3'd5;

  localparam logic [28:0] EXT_ID_MASK = 29'h1FFF_FFFF;

  typedef enum logic [1:0] {
    ST_GOOD        = 2'd0,
    ST_BAD_TRAILER = 2'd1,
    ST_BAD_TYPE    = 2'd2,
    ST_BAD_LENGTH  = 2'd3
  } status_t;

endpackage

FILE: hdl/uart_can_frame_deframer_unit.sv
// uart can frame deframer: byte stream in, one decoded can frame per trailer out
// depends on ucfd_pkg (constants, status codes)
`timescale 1ns / 1ps

// Takes one received serial byte per cycle. It waits for the start byte 0x40,
// then reads the length byte L and L+1 body bytes (type, big-endian id of 2 or
// 4 bytes, payload, trailer 0x1A); at the trailer it emits one frame with a
// status (good, bad trailer, bad type, bad length). Bad frames carry zeros in
// every field but status. Each byte passes through an input register and
// combinational decode logic into the result register, so the block
// sustains one byte per clock. A finished frame waits in the result register
// while further bytes keep flowing; only the trailer byte of the next frame
// stalls, and only while the previous frame is still unread.
module uart_can_frame_deframer_unit
  import ucfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,    // [7:0] rx_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata    // [1:0] status, [2] extended, [31:3] can_id,
                                    // [35:32] data_length, [43:36] data_0 ..
                                    // [99:92] data_7, [103:100] zero
);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  frame_length_r, frame_length_nxt;
  logic [7:0]  bytes_seen_r, bytes_seen_nxt;
  logic [7:0]  frame_type_r, frame_type_nxt;
  logic [31:0] id_r, id_nxt;
  logic [7:0]  store_r [MAX_PAYLOAD];

  logic        in_valid_r, in_valid_nxt;
  logic [7:0]  in_byte_r, in_byte_nxt;

  logic        out_valid_r, out_valid_nxt;
  status_t     out_status_r, out_status_nxt;
  logic        out_ext_r, out_ext_nxt;
  logic [28:0] out_id_r, out_id_nxt;
  logic [3:0]  out_dlc_r, out_dlc_nxt;
  logic [7:0]  out_data_r [MAX_PAYLOAD];
  logic [7:0]  out_data_nxt [MAX_PAYLOAD];

  logic                 store_we;
  logic [PIDX_W-1:0]    store_idx;
  logic [7:0]           b;
  logic [7:0]           idx;
  logic [7:0]           type_cur;
  logic                 ext;
  logic [2:0]           id_len;
  logic [2:0]           hdr;
  logic                 is_trailer;
  logic                 advance;
  logic [7:0]           pidx;
  logic [8:0]           dlc_wide;
  logic                 len_bad;

  always_comb begin
    b          = in_byte_r;
    idx        = bytes_seen_r;
    type_cur   = (idx == 8'd0) ? b : frame_type_r;
    ext        = (type_cur == TYPE_EXT);
    id_len     = ext ? ID_LEN_EXT : ID_LEN_STD;
    hdr        = ext ? HDR_EXT : HDR_STD;
    pidx       = idx - {5'd0, hdr};
    dlc_wide   = {1'b0, frame_length_r} - {6'd0, hdr};
    len_bad    = dlc_wide[8] || (dlc_wide[7:0] > 8'(MAX_PAYLOAD));
    is_trailer = (phase_r == PH_BODY) && (idx == frame_length_r);
    advance    = in_valid_r && (!is_trailer || !out_valid_r || out_tready);

    in_tready    = !in_valid_r || advance;
    in_valid_nxt = in_tready ? in_tvalid : in_valid_r;
    in_byte_nxt  = (in_tvalid && in_tready) ? in_tdata : in_byte_r;

    phase_nxt        = phase_r;
    frame_length_nxt = frame_length_r;
    bytes_seen_nxt   = bytes_seen_r;
    frame_type_nxt   = frame_type_r;
    id_nxt           = id_r;
    store_we         = 1'b0;
    store_idx        = pidx[PIDX_W-1:0];

    if (advance) begin
      case (phase_r)
        PH_HUNT: begin
          if (b == START_BYTE) begin
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          frame_length_nxt = b;
          bytes_seen_nxt   = 8'd0;
          frame_type_nxt   = 8'd0;
          id_nxt           = 32'd0;
          phase_nxt        = PH_BODY;
        end
        PH_BODY: begin
          frame_type_nxt = type_cur;
          if (idx >= 8'd1 && idx <= {5'd0, id_len}) begin
            id_nxt = {id_r[23:0], b};
          end else if (idx > {5'd0, id_len} && idx < frame_length_r &&
                       pidx < 8'(MAX_PAYLOAD)) begin
            store_we = 1'b1;
          end
          if (idx < frame_length_r) begin
            bytes_seen_nxt = idx + 8'd1;
          end else begin
            bytes_seen_nxt = 8'd0;
            phase_nxt      = PH_HUNT;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end

    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_ext_nxt    = out_ext_r;
    out_id_nxt     = out_id_r;
    out_dlc_nxt    = out_dlc_r;
    for (int k = 0; k < MAX_PAYLOAD; k++) begin
      out_data_nxt[k] = out_data_r[k];
    end

    if (advance && is_trailer) begin
      out_valid_nxt = 1'b1;
      out_ext_nxt   = 1'b0;
      out_id_nxt    = 29'd0;
      out_dlc_nxt   = 4'd0;
      for (int k = 0; k < MAX_PAYLOAD; k++) begin
        out_data_nxt[k] = 8'd0;
      end
      if (b != TRAILER_BYTE) begin
        out_status_nxt = ST_BAD_TRAILER;
      end else if (type_cur != TYPE_STD && type_cur != TYPE_EXT) begin
        out_status_nxt = ST_BAD_TYPE;
      end else if (len_bad) begin
        out_status_nxt = ST_BAD_LENGTH;
      end else begin
        out_status_nxt = ST_GOOD;
        out_ext_nxt    = ext;
        out_id_nxt     = ext ? (id_r[28:0] & EXT_ID_MASK) : {13'd0, id_r[15:0]};
        out_dlc_nxt    = dlc_wide[3:0];
        for (int k = 0; k < MAX_PAYLOAD; k++) begin
          if (4'(k) < dlc_wide[3:0]) begin
            out_data_nxt[k] = store_r[k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HUNT;
      frame_length_r <= 8'd0;
      bytes_seen_r   <= 8'd0;
      frame_type_r   <= 8'd0;
      id_r           <= 32'd0;
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      frame_length_r <= frame_length_nxt;
      bytes_seen_r   <= bytes_seen_nxt;
      frame_type_r   <= frame_type_nxt;
      id_r           <= id_nxt;
      in_valid_r     <= in_valid_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    in_byte_r    <= in_byte_nxt;
    out_status_r <= out_status_nxt;
    out_ext_r    <= out_ext_nxt;
    out_id_r     <= out_id_nxt;
    out_dlc_r    <= out_dlc_nxt;
    for (int k = 0; k < MAX_PAYLOAD; k++) begin
      out_data_r[k] <= out_data_nxt[k];
    end
    if (store_we) begin
      store_r[store_idx] <= b;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0,
                       out_data_r[7], out_data_r[6], out_data_r[5], out_data_r[4],
                       out_data_r[3], out_data_r[2], out_data_r[1], out_data_r[0],
                       out_dlc_r, out_id_r, out_ext_r, out_status_r};

  // frame end always returns to hunting
  a_trailer_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && is_trailer) |=> (phase_r == PH_HUNT && out_valid_r))
    else $error("trailer did not close the frame");

  // body counter never passes the trailer position
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (bytes_seen_r <= frame_length_r))
    else $error("body byte count beyond frame length");

  // good frames stay within payload limit
  a_good_dlc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_GOOD) |-> (out_dlc_r <= 4'(MAX_PAYLOAD)))
    else $error("good frame with oversize payload");

  // bad frames carry only a status
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_GOOD) |->
      (out_tdata[103:2] == 102'd0))
    else $error("bad frame carries nonzero fields");

  // a held result never blocks non-trailer bytes
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !is_trailer) |-> in_tready)
    else $error("input stalled on a byte that gives no result");

endmodule
